@@ hw/rtl/ibt_pkg.sv @@
// shared types, codes and constants of the inactivity blank timer
package ibt_pkg;

    // event codes carried in event_kind
    localparam logic [1:0] EV_TICK     = 2'd0;
    localparam logic [1:0] EV_ACTIVITY = 2'd1;
    localparam logic [1:0] EV_PROGRESS = 2'd2;

    // register indexes
    localparam logic REG_BLANK_SECONDS = 1'b0;

    // widths fixed by the fields and state
    localparam int SECONDS_W   = 14;
    localparam int REMAIN_W    = 17;
    localparam int PATTERN_W   = 10;
    localparam int STALL_W     = 6;
    localparam int TPS_W       = 4;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [SECONDS_W-1:0] MAX_SECONDS    = 14'd9999;
    localparam logic [SECONDS_W-1:0] RESET_SECONDS  = 14'd60;
    localparam logic [PATTERN_W-1:0] PATTERN_RELOAD = 10'd600;
    localparam logic [STALL_W-1:0]   STALL_MAX      = 6'd63;

    // parameter defaults
    localparam int STALL_LIMIT_DEF      = 40;
    localparam int PATTERN_INTERVAL_DEF = 600;
    localparam int TICKS_PER_SECOND_DEF = 10;

    typedef struct packed {
        logic [1:0] event_kind;
        logic       button_held;
    } in_item_t;

    typedef struct packed {
        logic blank_request;
        logic unblank_request;
        logic force_black;
        logic pattern_change;
        logic is_blanked;
    } out_item_t;

    // timeout reload from the register port
    typedef struct packed {
        logic                wr;
        logic [REMAIN_W-1:0] interval;
    } cfg_t;

endpackage

@@ hw/rtl/inactivity_blank_timer.sv @@
// top level of the screen-blanker inactivity timer with stall watchdog
//
// usage
// - input channel s_valid/s_ready/s_item: one request per event, a 10 Hz tick,
//   a user-activity event or an animation-progress heartbeat
// - result channel m_valid/m_ready/m_item: exactly one result per request,
//   in request order, carrying blank/unblank requests, force_black,
//   pattern_change and the blanked status after that request
// - register port (apb style, pready tied high): blank_seconds at address 0, its
//   timeout clamped to 1..9999 s; a write reloads the timeout and pattern counter
// - a request accepted on s_ready passes the input register, then the decision
//   logic into the result register, before it shows on m_valid
// - throughput: one request per cycle while the receiver keeps m_ready high
// - a stalled receiver holds the result register; the input register still
//   takes one more request, after which s_ready drops until m_ready returns
// - reset (aresetn low, synchronous): timer reloaded to 60 s, not blanked,
//   stall count cleared, both channels empty
// - write registers only while no request is in flight
module inactivity_blank_timer #(
    parameter int STALL_LIMIT      = ibt_pkg::STALL_LIMIT_DEF,
    parameter int PATTERN_INTERVAL = ibt_pkg::PATTERN_INTERVAL_DEF,
    parameter int TICKS_PER_SECOND = ibt_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ibt_pkg::in_item_t          s_item,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ibt_pkg::out_item_t         m_item,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ibt_pkg::ADDR_W-1:0] paddr,
    input  logic [ibt_pkg::DATA_W-1:0] pwdata,
    output logic [ibt_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    // input register
    logic              in_valid_reg, in_valid_next;
    ibt_pkg::in_item_t in_item_reg;

    logic                         space;
    logic                         advance;
    logic                         take;
    ibt_pkg::cfg_t                cfg;
    logic [ibt_pkg::REMAIN_W-1:0] interval;
    ibt_pkg::out_item_t           result;

    // a held request moves on whenever the result register can take it
    assign advance = in_valid_reg && space;
    assign s_ready = !in_valid_reg || space;
    assign take    = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_item_reg <= s_item;
        end
    end

    // register port and clamped interval
    ibt_cfg #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .interval (interval)
    );

    // timeout, pattern and stall state
    ibt_core #(
        .STALL_LIMIT      (STALL_LIMIT),
        .PATTERN_INTERVAL (PATTERN_INTERVAL),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .item     (in_item_reg),
        .cfg      (cfg),
        .interval (interval),
        .result   (result)
    );

    // result register
    ibt_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .result  (result),
        .space   (space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

@@ hw/rtl/ibt_cfg.sv @@
// register port: blank_seconds, clamped timeout interval and reload strobe
module ibt_cfg #(
    parameter int TICKS_PER_SECOND = ibt_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ibt_pkg::ADDR_W-1:0]   paddr,
    input  logic [ibt_pkg::DATA_W-1:0]   pwdata,
    output logic [ibt_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output ibt_pkg::cfg_t                cfg,
    output logic [ibt_pkg::REMAIN_W-1:0] interval
);

    localparam logic [ibt_pkg::TPS_W-1:0] TPS = ibt_pkg::TPS_W'(TICKS_PER_SECOND);
    localparam logic [ibt_pkg::REMAIN_W-1:0] RESET_INTERVAL =
        ibt_pkg::REMAIN_W'(60 * TICKS_PER_SECOND);

    logic [ibt_pkg::SECONDS_W-1:0] seconds_reg, seconds_next;
    logic [ibt_pkg::REMAIN_W-1:0]  interval_reg, interval_next;
    logic [ibt_pkg::SECONDS_W-1:0] wr_secs;
    logic [ibt_pkg::SECONDS_W-1:0] clamped;
    logic                          wr_en;

    assign pready  = 1'b1;
    assign wr_secs = pwdata[ibt_pkg::SECONDS_W-1:0];
    assign wr_en   = psel && penable && pwrite && (paddr[2] == ibt_pkg::REG_BLANK_SECONDS);

    always_comb begin
        priority if (wr_secs == '0) begin
            clamped = ibt_pkg::SECONDS_W'(1);
        end else if (wr_secs > ibt_pkg::MAX_SECONDS) begin
            clamped = ibt_pkg::MAX_SECONDS;
        end else begin
            clamped = wr_secs;
        end
    end

    always_comb begin
        seconds_next  = seconds_reg;
        interval_next = interval_reg;
        if (wr_en) begin
            seconds_next  = wr_secs;
            interval_next = ibt_pkg::REMAIN_W'(clamped) * ibt_pkg::REMAIN_W'(TPS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seconds_reg  <= ibt_pkg::RESET_SECONDS;
            interval_reg <= RESET_INTERVAL;
        end else begin
            seconds_reg  <= seconds_next;
            interval_reg <= interval_next;
        end
    end

    assign prdata = (paddr[2] == ibt_pkg::REG_BLANK_SECONDS)
                    ? ibt_pkg::DATA_W'(seconds_reg) : '0;

    assign cfg.wr       = wr_en;
    assign cfg.interval = interval_next;
    assign interval     = interval_reg;

endmodule

@@ hw/rtl/ibt_core.sv @@
// timer state and per-request decision logic
module ibt_core #(
    parameter int STALL_LIMIT      = ibt_pkg::STALL_LIMIT_DEF,
    parameter int PATTERN_INTERVAL = ibt_pkg::PATTERN_INTERVAL_DEF,
    parameter int TICKS_PER_SECOND = ibt_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  ibt_pkg::in_item_t            item,
    input  ibt_pkg::cfg_t                cfg,
    input  logic [ibt_pkg::REMAIN_W-1:0] interval,
    output ibt_pkg::out_item_t           result
);

    localparam logic [ibt_pkg::PATTERN_W:0] PAT_LIMIT =
        (ibt_pkg::PATTERN_W + 1)'(PATTERN_INTERVAL);
    localparam logic [ibt_pkg::STALL_W-1:0] STALL_LIM = ibt_pkg::STALL_W'(STALL_LIMIT);
    localparam logic [ibt_pkg::REMAIN_W-1:0] RESET_INTERVAL =
        ibt_pkg::REMAIN_W'(60 * TICKS_PER_SECOND);

    logic [ibt_pkg::REMAIN_W-1:0]  remain_reg, remain_next;
    logic [ibt_pkg::PATTERN_W-1:0] pattern_reg, pattern_next;
    logic [ibt_pkg::STALL_W-1:0]   stall_reg, stall_next;
    logic                          seen_reg, seen_next;
    logic                          blanked_reg, blanked_next;

    logic [ibt_pkg::PATTERN_W:0]   pat_inc;
    logic [ibt_pkg::STALL_W-1:0]   stall_inc;

    assign pat_inc   = {1'b0, pattern_reg} + 1'b1;
    assign stall_inc = (stall_reg < ibt_pkg::STALL_MAX) ? stall_reg + 1'b1 : stall_reg;

    always_comb begin
        remain_next  = remain_reg;
        pattern_next = pattern_reg;
        stall_next   = stall_reg;
        seen_next    = seen_reg;
        blanked_next = blanked_reg;
        result       = '0;
        if (cfg.wr) begin
            remain_next  = cfg.interval;
            pattern_next = ibt_pkg::PATTERN_RELOAD;
        end else if (advance) begin
            unique case (item.event_kind)
                ibt_pkg::EV_TICK: begin
                    // stall and pattern logic see the status before the tick
                    if (blanked_reg) begin
                        if (pat_inc >= PAT_LIMIT) begin
                            pattern_next          = '0;
                            result.pattern_change = 1'b1;
                        end else begin
                            pattern_next = pat_inc[ibt_pkg::PATTERN_W-1:0];
                        end
                        if (!seen_reg) begin
                            stall_next         = stall_inc;
                            result.force_black = (stall_inc >= STALL_LIM);
                        end else begin
                            seen_next  = 1'b0;
                            stall_next = '0;
                        end
                    end
                    if (remain_reg == '0) begin
                        // held button keeps the counter parked at zero
                        if (!item.button_held) begin
                            result.blank_request = 1'b1;
                            remain_next          = interval;
                            if (!blanked_reg) begin
                                pattern_next = '0;
                            end
                            blanked_next = 1'b1;
                            stall_next   = '0;
                            seen_next    = 1'b0;
                        end
                    end else begin
                        remain_next = remain_reg - 1'b1;
                    end
                end
                ibt_pkg::EV_ACTIVITY: begin
                    if (blanked_reg) begin
                        result.unblank_request = 1'b1;
                        blanked_next           = 1'b0;
                        stall_next             = '0;
                        seen_next              = 1'b0;
                    end
                    remain_next = interval;
                end
                ibt_pkg::EV_PROGRESS: begin
                    if (blanked_reg) begin
                        seen_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        result.is_blanked = blanked_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg  <= RESET_INTERVAL;
            pattern_reg <= ibt_pkg::PATTERN_RELOAD;
            stall_reg   <= '0;
            seen_reg    <= 1'b0;
            blanked_reg <= 1'b0;
        end else begin
            remain_reg  <= remain_next;
            pattern_reg <= pattern_next;
            stall_reg   <= stall_next;
            seen_reg    <= seen_next;
            blanked_reg <= blanked_next;
        end
    end

endmodule

@@ hw/rtl/ibt_out_stage.sv @@
// result register on the outgoing channel
module ibt_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  ibt_pkg::out_item_t  result,
    output logic                space,
    output logic                m_valid,
    input  logic                m_ready,
    output ibt_pkg::out_item_t  m_item
);

    logic               valid_reg, valid_next;
    ibt_pkg::out_item_t item_reg;

    assign space = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule
